FILE: sv/fqs_pkg.sv
// Shared constants and types for the searchable FIFO queue.
`default_nettype none
package fqs_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int WORD_W      = 32;
   localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int COUNT_W     = 5;
   localparam int REQ_W       = 2;
   localparam int STATUS_W    = 2;

   localparam logic [REQ_W-1:0] REQ_ENQUEUE = 2'd0;
   localparam logic [REQ_W-1:0] REQ_DEQUEUE = 2'd1;
   localparam logic [REQ_W-1:0] REQ_SEARCH  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   // Control broadcast to every cell of the chain.
   typedef struct packed {
      logic              shift;
      logic              load;
      logic [WORD_W-1:0] value;
   } cell_ctl_type;

   // What one cell shows to its neighbors and to the top level.
   typedef struct packed {
      logic              valid;
      logic              match;
      logic [WORD_W-1:0] word;
   } cell_out_type;

endpackage
`default_nettype wire

FILE: sv/fqs_cell.sv
// One storage cell of the queue chain: holds a word, shifts toward the head, compares.
`default_nettype none
module fqs_cell (
   input  wire                           clock,
   input  wire                           reset,
   input  wire fqs_pkg::cell_ctl_type    ctl,
   input  wire                           prev_valid,
   input  wire                           next_valid,
   input  wire  [fqs_pkg::WORD_W-1:0]    next_word,
   output fqs_pkg::cell_out_type         cell_out
);

   logic                       valid_ff, valid_in;
   logic [fqs_pkg::WORD_W-1:0] word_ff, word_in;

   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      if (ctl.shift) begin
         // take the neighbor's word one step closer to the head
         valid_in = next_valid;
         word_in  = next_word;
      end else if (ctl.load && !valid_ff && prev_valid) begin
         // first free cell captures the new word
         valid_in = 1'b1;
         word_in  = ctl.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign cell_out.valid = valid_ff;
   assign cell_out.word  = word_ff;
   assign cell_out.match = valid_ff && (word_ff == ctl.value);

endmodule
`default_nettype wire

FILE: sv/fifo_queue_with_search.sv
// Top level of the searchable FIFO queue built from a chain of storage cells.
// Latency: a result appears in the cycle after its request is accepted.
// Throughput: one request per cycle unless the result channel stalls; the cell chain
// updates with the result register; a search compares all cells at once, OR-reduced.
// The result register lets a new request in while the previous result is taken.
// Reset (synchronous, active high) empties the queue and drops any pending result.
`default_nettype none
module fifo_queue_with_search (
   input  wire         clock,
   input  wire         reset,
   // request channel
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [31:0] req_tdata,   // [31:0] value
   input  wire  [1:0]  req_tuser,   // [1:0] req_type
   // result channel
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] data, [32] found, [37:33] count, [39:38] zero
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   localparam int DEPTH = fqs_pkg::QUEUE_DEPTH;

   // request fields
   logic [fqs_pkg::REQ_W-1:0]  req_kind;
   logic [fqs_pkg::WORD_W-1:0] req_value;
   logic                       req_fire;

   // queue level and result register
   logic [fqs_pkg::FILL_W-1:0]   fill_ff, fill_in;
   logic                         rsp_valid_ff;
   logic [fqs_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [fqs_pkg::WORD_W-1:0]   data_ff, data_in;
   logic                         found_ff, found_in;

   logic                  is_full, is_empty, do_enq, do_deq;
   logic [DEPTH-1:0]      match_vec;
   fqs_pkg::cell_ctl_type ctl;
   fqs_pkg::cell_out_type cell_out [DEPTH];

   assign req_kind  = req_tuser;
   assign req_value = req_tdata;

   // accept whenever the result register is free or being emptied
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   assign is_full  = (fill_ff == fqs_pkg::FILL_W'(DEPTH));
   assign is_empty = (fill_ff == '0);
   assign do_enq   = req_fire && (req_kind == fqs_pkg::REQ_ENQUEUE) && !is_full;
   assign do_deq   = req_fire && (req_kind == fqs_pkg::REQ_DEQUEUE) && !is_empty;

   // broadcast control: shift on dequeue, load the first free cell on enqueue
   assign ctl.shift = do_deq;
   assign ctl.load  = do_enq;
   assign ctl.value = req_value;

   // cell chain: cell 0 holds the oldest word, data moves toward it on dequeue
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                       prev_valid, next_valid;
      logic [fqs_pkg::WORD_W-1:0] next_word;

      if (i == 0) begin : g_first
         assign prev_valid = 1'b1;
      end else begin : g_inner_prev
         assign prev_valid = cell_out[i-1].valid;
      end

      if (i == DEPTH - 1) begin : g_last
         assign next_valid = 1'b0;
         assign next_word  = '0;
      end else begin : g_inner_next
         assign next_valid = cell_out[i+1].valid;
         assign next_word  = cell_out[i+1].word;
      end

      fqs_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .prev_valid (prev_valid),
         .next_valid (next_valid),
         .next_word  (next_word),
         .cell_out   (cell_out[i])
      );

      assign match_vec[i] = cell_out[i].match;
   end

   // next fill level and result fields
   always_comb begin
      fill_in   = fill_ff;
      status_in = fqs_pkg::STATUS_OK;
      data_in   = '0;
      found_in  = 1'b0;
      unique case (req_kind)
         fqs_pkg::REQ_ENQUEUE: begin
            if (is_full) begin
               status_in = fqs_pkg::STATUS_FULL;   // drop the word
            end else begin
               fill_in = fill_ff + 1'b1;
            end
         end
         fqs_pkg::REQ_DEQUEUE: begin
            if (is_empty) begin
               status_in = fqs_pkg::STATUS_EMPTY;  // hold the queue as is
            end else begin
               fill_in = fill_ff - 1'b1;
               data_in = cell_out[0].word;
            end
         end
         fqs_pkg::REQ_SEARCH: begin
            found_in = |match_vec;
         end
         default: begin
            // unused request code: no operation
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            fill_ff      <= fill_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         status_ff <= status_in;
         data_ff   <= data_in;
         found_ff  <= found_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {2'b00, fqs_pkg::COUNT_W'(fill_ff), found_ff, data_ff};

endmodule
`default_nettype wire
